// ===== design/lsk_pkg.sv =====
// types and constants shared by the led scan shifter and key sampler
`default_nettype none
package lsk_pkg;

  localparam int unsigned KEY_COUNT = 5;
  localparam int unsigned SEL_BASE  = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [2:0] digit_index;
    logic [7:0] digit_value;
    logic [5:0] key_bits;
  } lsk_in_t;

  typedef struct packed {
    logic                 serial_bit;
    logic                 frame_last;
    logic [2:0]           scan_digit;
    logic [KEY_COUNT-1:0] keys_held;
    logic [KEY_COUNT-1:0] keys_long;
  } lsk_out_t;

endpackage
`default_nettype wire

// ===== design/led_scan_shift_and_key_sample.sv =====
// led scan shifter: digit store, serial frame output and key long-press tracking
// latency: a scan tick's first frame bit is offered the cycle after acceptance
// throughput: one frame bit per cycle from the output shift register while out_ready_i
//   is high; the next item is taken as the last bit leaves
// digit writes update the store and give no output
// reset clears digit store, position, key state and sets threshold to 2
`default_nettype none
module led_scan_shift_and_key_sample
  import lsk_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 5,
  parameter int unsigned FRAME_BITS  = 15
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire lsk_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output lsk_out_t      out_data_o
);

  localparam int unsigned IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(FRAME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

  logic [7:0]            store_q [DIGIT_COUNT];
  logic [2:0]            pos_q, pos_d;
  logic [KEY_COUNT-1:0]  cur_keys_q, cur_keys_d;
  logic [1:0]            hold_q [KEY_COUNT];
  logic [1:0]            hold_d [KEY_COUNT];
  logic [KEY_COUNT-1:0]  long_q, long_d;
  logic [1:0]            thresh_q;

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [FRAME_BITS-1:0] word_q, word_d;
  logic [2:0]            frame_pos_q;

  logic                  in_fire, out_fire, last_fire, scan_fire;
  logic [2:0]            pos_cur;
  logic [3:0]            pos_inc;

  assign out_valid_o = busy_q;
  assign out_fire    = out_valid_o && out_ready_i;
  assign last_fire   = out_fire && (cnt_q == CNT_LAST);
  assign in_ready_o  = !busy_q || last_fire;
  assign in_fire     = in_valid_i && in_ready_o;
  assign scan_fire   = in_fire && (in_data_i.opcode == OP_SCAN);

  // a stale position beyond the store falls back to digit zero
  assign pos_cur = ({1'b0, pos_q} < 4'(DIGIT_COUNT)) ? pos_q : 3'd0;
  assign pos_inc = {1'b0, pos_cur} + 4'd1;
  assign pos_d   = (pos_inc >= 4'(DIGIT_COUNT)) ? 3'd0 : pos_inc[2:0];

  always_comb begin
    for (int b = 0; b < FRAME_BITS; b++) begin
      if (b < SEL_BASE) begin
        word_d[b] = store_q[pos_cur[IDX_W-1:0]][b];
      end else begin
        // active low digit select
        word_d[b] = ({1'b0, pos_cur} != 4'(b - SEL_BASE));
      end
    end
  end

  always_comb begin
    logic [2:0] inc;
    logic [1:0] c;
    cur_keys_d = in_data_i.key_bits[KEY_COUNT-1:0];
    for (int k = 0; k < KEY_COUNT; k++) begin
      inc = {1'b0, hold_q[k]} + 3'd1;
      c   = (inc > {1'b0, thresh_q}) ? thresh_q : inc[1:0];
      if (cur_keys_q[k] && cur_keys_d[k]) begin
        hold_d[k] = c;
        long_d[k] = long_q[k] || (c >= thresh_q);
      end else begin
        hold_d[k] = 2'd0;
        long_d[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < DIGIT_COUNT; e++) begin
        store_q[e] <= 8'h00;
      end
      for (int k = 0; k < KEY_COUNT; k++) begin
        hold_q[k] <= 2'd0;
      end
      pos_q      <= 3'd0;
      cur_keys_q <= '0;
      long_q     <= '0;
      thresh_q   <= 2'd2;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (in_fire && (in_data_i.opcode == OP_WRITE)) begin
        for (int e = 0; e < DIGIT_COUNT; e++) begin
          if (in_data_i.digit_index == 3'(e)) begin
            store_q[e] <= in_data_i.digit_value;
          end
        end
      end
      if (scan_fire) begin
        pos_q      <= pos_d;
        cur_keys_q <= cur_keys_d;
        long_q     <= long_d;
        for (int k = 0; k < KEY_COUNT; k++) begin
          hold_q[k] <= hold_d[k];
        end
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (last_fire) begin
        busy_q <= 1'b0;
      end else if (out_fire) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // frame payload, loaded per scan transaction and shifted msb first
  always_ff @(posedge clk_i) begin
    if (scan_fire) begin
      word_q      <= word_d;
      frame_pos_q <= pos_cur;
    end else if (out_fire) begin
      word_q <= {word_q[FRAME_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    out_data_o.serial_bit = word_q[FRAME_BITS-1];
    out_data_o.frame_last = (cnt_q == CNT_LAST);
    out_data_o.scan_digit = frame_pos_q;
    out_data_o.keys_held  = cur_keys_q;
    out_data_o.keys_long  = long_q;
  end

`ifndef NO_ASSERTIONS
  // a scan transaction starts a fresh frame at its first bit
  a_scan_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_fire |=> (out_valid_o && (cnt_q == '0)))
    else $error("scan did not start a frame");

  // a frame keeps going until its last bit is taken
  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_fire) |=> out_valid_o)
    else $error("frame ended early");

  // digit and key report stay fixed across one frame
  a_frame_fields_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_fire) |=> ($stable(out_data_o.scan_digit)
                                  && $stable(out_data_o.keys_long)))
    else $error("frame fields changed mid frame");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_led_scan_shift_and_key_sample.sv =====
// testbench for the led scan shifter: frame bits, digit store and key long-press tracking
module tb_led_scan_shift_and_key_sample;
  timeunit 1ns;
  timeprecision 1ps;

  import lsk_pkg::*;

  localparam int unsigned DIGITS     = 5;
  localparam int unsigned FRAME_LEN  = 15;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned SETTLE_CYC = 4;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;
  logic       in_valid = 1'b0;
  lsk_in_t    in_data = '0;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  lsk_out_t   out_data_o;

  // shadow state of the block
  logic [7:0] digit_mem [DIGITS];
  logic [2:0] scan_pos;
  logic [4:0] prev_keys;
  logic [4:0] cur_keys;
  logic [1:0] hold_cnt [KEY_COUNT];
  logic [4:0] long_keys;
  logic [1:0] threshold;

  lsk_out_t    pending_frame_bits [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;

  led_scan_shift_and_key_sample #(
    .DIGIT_COUNT(DIGITS),
    .FRAME_BITS (FRAME_LEN)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < 40)
      $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // works out the frame bits that one accepted item produces
  function automatic void predict_frame_bits(lsk_in_t item);
    logic [FRAME_LEN-1:0] frame_word;
    lsk_out_t             slot;
    int unsigned          cnt;
    if (item.opcode == OP_WRITE) begin
      if (item.digit_index < DIGITS)
        digit_mem[item.digit_index] = item.digit_value;
      return;
    end
    frame_word = '1;
    frame_word[SEL_BASE + scan_pos] = 1'b0;
    frame_word[7:0] = digit_mem[scan_pos];

    prev_keys = cur_keys;
    cur_keys  = item.key_bits[4:0];
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (prev_keys[k] && cur_keys[k]) begin
        cnt = hold_cnt[k] + 1;
        if (cnt > threshold)
          cnt = threshold;
        hold_cnt[k] = cnt[1:0];
        if (cnt >= threshold)
          long_keys[k] = 1'b1;
      end else begin
        hold_cnt[k]  = 2'd0;
        long_keys[k] = 1'b0;
      end
    end

    for (int b = FRAME_LEN - 1; b >= 0; b--) begin
      slot.serial_bit = frame_word[b];
      slot.frame_last = (b == 0);
      slot.scan_digit = scan_pos;
      slot.keys_held  = cur_keys;
      slot.keys_long  = long_keys;
      pending_frame_bits.push_back(slot);
    end
    scan_pos = (scan_pos == DIGITS - 1) ? 3'd0 : scan_pos + 3'd1;
  endfunction

  always @(posedge clk_i) begin
    lsk_out_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_frame_bits.size() == 0) begin
        report_mismatch("unexpected transaction", out_data_o, 0);
      end else begin
        want = pending_frame_bits.pop_front();
        if (out_data_o.serial_bit !== want.serial_bit)
          report_mismatch("serial_bit", out_data_o.serial_bit, want.serial_bit);
        if (out_data_o.frame_last !== want.frame_last)
          report_mismatch("frame_last", out_data_o.frame_last, want.frame_last);
        if (out_data_o.scan_digit !== want.scan_digit)
          report_mismatch("scan_digit", out_data_o.scan_digit, want.scan_digit);
        if (out_data_o.keys_held !== want.keys_held)
          report_mismatch("keys_held", out_data_o.keys_held, want.keys_held);
        if (out_data_o.keys_long !== want.keys_long)
          report_mismatch("keys_long", out_data_o.keys_long, want.keys_long);
      end
    end
  end

  // leaves valid high after acceptance so back-to-back transactions need no gap
  task automatic send_item(lsk_in_t item);
    int unsigned gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame_bits(item);
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    go_idle();
    while (pending_frame_bits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    threshold = value;
  endtask

  task automatic send_write(int unsigned idx, int unsigned value);
    lsk_in_t item;
    item             = '0;
    item.opcode      = OP_WRITE;
    item.digit_index = idx[2:0];
    item.digit_value = value[7:0];
    send_item(item);
  endtask

  task automatic send_scan(logic [5:0] keys);
    lsk_in_t item;
    item          = '0;
    item.opcode   = OP_SCAN;
    item.key_bits = keys;
    send_item(item);
  endtask

  // store extremes, out-of-range indexes, all positions, bit 5 of keys ignored
  task automatic test_directed();
    logic [5:0] key_seq [12];
    key_seq = '{6'h3F, 6'h3F, 6'h1F, 6'h20, 6'h15, 6'h15, 6'h15, 6'h0A,
                6'h00, 6'h1F, 6'h1F, 6'h1F};
    send_write(0, 8'h00);
    send_write(1, 8'hFF);
    send_write(2, 8'hA5);
    send_write(3, 8'h5A);
    send_write(4, 8'h81);
    // writes past the store are dropped
    send_write(5, 8'hFF);
    send_write(6, 8'h3C);
    send_write(7, 8'hFF);
    foreach (key_seq[i])
      send_scan(key_seq[i]);
    go_idle();
  endtask

  // threshold zero, one and the maximum, with held and released keys
  task automatic test_threshold_extremes();
    logic [1:0] thr_seq [3];
    thr_seq = '{2'd0, 2'd1, 2'd3};
    foreach (thr_seq[t]) begin
      set_threshold(thr_seq[t]);
      repeat (4) send_scan(6'h1F);
      send_scan(6'h00);
      send_scan(6'h05);
      send_scan(6'h25);
      go_idle();
    end
  endtask

  // mostly sustained key patterns with sparse flips, some noise and store writes
  task automatic test_random_traffic();
    int unsigned sender_pct [4];
    int unsigned stall_pct [4];
    logic [1:0]  thr_seq [4];
    logic [4:0]  held;
    logic [5:0]  keys;
    int unsigned idx;
    sender_pct = '{0, 48, 0, 18};
    stall_pct  = '{0, 0, 48, 18};
    thr_seq    = '{2'd2, 2'd0, 2'd3, 2'd1};
    held = 5'h00;
    for (int ph = 0; ph < 4; ph++) begin
      set_threshold(thr_seq[ph]);
      sender_idle_pct = sender_pct[ph];
      recv_stall_pct  = stall_pct[ph];
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(99) < 25) begin
          idx = ($urandom_range(99) < 85) ? $urandom_range(0, DIGITS - 1) : $urandom_range(5, 7);
          send_write(idx, $urandom_range(0, 255));
        end else begin
          if ($urandom_range(99) < 10)
            held = $urandom_range(0, 31);
          else if ($urandom_range(99) < 25)
            held[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
          keys = {1'($urandom_range(0, 1)), held};
          send_scan(keys);
        end
      end
      // hold off until the block has emitted everything
      drain();
    end
  endtask

  initial begin
    error_count     = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    foreach (digit_mem[i]) digit_mem[i] = 8'h00;
    foreach (hold_cnt[i]) hold_cnt[i] = 2'd0;
    scan_pos  = 3'd0;
    prev_keys = 5'h00;
    cur_keys  = 5'h00;
    long_keys = 5'h00;
    threshold = 2'd2;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_threshold_extremes();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
